>>> rtl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, codes and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MAG, ACT_NEG, ACT_INC, ACT_DEC
  } action_t;

  typedef enum logic [1:0] {
    KIND_SIMPLE, KIND_MUL, KIND_DIV, KIND_MAG
  } kind_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROD, ST_SUM, ST_PREP, ST_DIV, ST_SQRT, ST_FIN
  } bstate_t;

  typedef struct packed {
    action_t            action;
    kind_t              kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qport_t;

  function automatic kind_t classify(action_t act);
    kind_t k;
    unique case (act)
      ACT_MUL: k = KIND_MUL;
      ACT_DIV: k = KIND_DIV;
      ACT_MAG: k = KIND_MAG;
      default: k = KIND_SIMPLE;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/cau_if.sv
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

>>> rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Takes operand beats and tags each with its execution class.
// ----------------------------------------------------------------------------
module cau_front (
  cau_in_if.sink         in_chan,
  input  logic           q_full,
  output cau_pkg::qport_t push
);

  cau_pkg::action_t act;

  assign act           = cau_pkg::action_t'(in_chan.action);
  assign in_chan.ready = !q_full;

  always_comb begin
    push.valid       = in_chan.valid && !q_full;
    push.item.action = act;
    push.item.kind   = cau_pkg::classify(act);
    push.item.a_re   = in_chan.a_re;
    push.item.a_im   = in_chan.a_im;
    push.item.b_re   = in_chan.b_re;
    push.item.b_im   = in_chan.b_im;
  end

endmodule

>>> rtl/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module cau_queue #(
  parameter int DEPTH = cau_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cau_pkg::qport_t push,
  input  logic            pop,
  output cau_pkg::qport_t head,
  output logic            full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cau_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rp_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wrap_inc(wp_r);
      if (do_pop)  rp_r <= wrap_inc(rp_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution: simple ops from the queue head, shared multiplier, bit-serial
// divider and square root, registered result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_back #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cau_pkg::qport_t head,
  output logic            pop,
  cau_out_if.source       out_chan
);

  localparam int NW         = 64 + FRAC_BITS;
  localparam int CW         = $clog2(NW + 1);
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } satv_t;

  cau_pkg::bstate_t   state_r, state_nxt;
  cau_pkg::item_t     it_r;
  logic [2:0]         pc_r;
  logic signed [63:0] p_r [6];
  logic signed [64:0] s_re_r, s_im_r;
  logic [63:0]        d_r;
  logic               dz_r;
  logic [CW-1:0]      cnt_r;
  logic [NW-1:0]      n_re_r, n_im_r;
  logic [63:0]        r_re_r, r_im_r;
  logic [32:0]        q_re_r, q_im_r;
  logic               ov_re_r, ov_im_r;
  logic [63:0]        sx_r, sres_r, sbit_r;
  logic               out_valid_r;
  logic signed [31:0] ore_r, oim_r;
  logic [1:0]         ost_r;

  logic               out_free, prod_last, load_simple, load_fin;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod;
  satv_t              sim_re, sim_im, fin_re, fin_im;
  logic [1:0]         fin_st;

  function automatic satv_t sat65(logic signed [64:0] v);
    satv_t r;
    if (v > 65'sd2147483647) begin
      r = '{sat: 1'b1, val: 32'h7FFF_FFFF};
    end else if (v < -65'sd2147483648) begin
      r = '{sat: 1'b1, val: 32'h8000_0000};
    end else begin
      r = '{sat: 1'b0, val: v[31:0]};
    end
    return r;
  endfunction

  function automatic satv_t sat_sm(logic [32:0] m, logic ovf, logic neg);
    satv_t       r;
    logic [32:0] nm;
    nm = -m;
    if (neg) begin
      if (ovf || m > 33'h0_8000_0000) r = '{sat: 1'b1, val: 32'h8000_0000};
      else                            r = '{sat: 1'b0, val: nm[31:0]};
    end else begin
      if (ovf || m > 33'h0_7FFF_FFFF) r = '{sat: 1'b1, val: 32'h7FFF_FFFF};
      else                            r = '{sat: 1'b0, val: m[31:0]};
    end
    return r;
  endfunction

  function automatic logic [63:0] abs65(logic signed [64:0] v);
    logic [64:0] n;
    n = -v;
    return v[64] ? n[63:0] : v[63:0];
  endfunction

  assign out_free = !out_valid_r || out_chan.ready;

  // simple ops straight from the queue head
  always_comb begin
    logic signed [64:0] ar, ai, br, bi, one;
    ar  = 65'(head.item.a_re);
    ai  = 65'(head.item.a_im);
    br  = 65'(head.item.b_re);
    bi  = 65'(head.item.b_im);
    one = 65'sd1 <<< FRAC_BITS;
    case (head.item.action)
      cau_pkg::ACT_ADD: begin sim_re = sat65(ar + br); sim_im = sat65(ai + bi); end
      cau_pkg::ACT_SUB: begin sim_re = sat65(ar - br); sim_im = sat65(ai - bi); end
      cau_pkg::ACT_NEG: begin sim_re = sat65(-ar);     sim_im = sat65(-ai);     end
      cau_pkg::ACT_INC: begin
        sim_re = sat65(ar + one);
        sim_im = '{sat: 1'b0, val: head.item.a_im};
      end
      default: begin
        sim_re = sat65(ar - one);
        sim_im = '{sat: 1'b0, val: head.item.a_im};
      end
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    opa = it_r.a_im;
    opb = it_r.a_im;
    case (it_r.kind)
      cau_pkg::KIND_MUL: begin
        case (pc_r)
          3'd0:    begin opa = it_r.a_re; opb = it_r.b_re; end
          3'd1:    begin opa = it_r.a_im; opb = it_r.b_im; end
          3'd2:    begin opa = it_r.a_im; opb = it_r.b_re; end
          default: begin opa = it_r.a_re; opb = it_r.b_im; end
        endcase
      end
      cau_pkg::KIND_DIV: begin
        case (pc_r)
          3'd0:    begin opa = it_r.b_re; opb = it_r.b_re; end
          3'd1:    begin opa = it_r.b_im; opb = it_r.b_im; end
          3'd2:    begin opa = it_r.a_re; opb = it_r.b_re; end
          3'd3:    begin opa = it_r.a_im; opb = it_r.b_im; end
          3'd4:    begin opa = it_r.a_im; opb = it_r.b_re; end
          default: begin opa = it_r.a_re; opb = it_r.b_im; end
        endcase
      end
      default: begin
        if (pc_r == 3'd0) begin opa = it_r.a_re; opb = it_r.a_re; end
      end
    endcase
  end

  // signed 32x32 product, operands sign-extended to the product width
  assign prod = 64'(opa) * 64'(opb);

  always_comb begin
    case (it_r.kind)
      cau_pkg::KIND_MUL: prod_last = (pc_r == 3'd3);
      cau_pkg::KIND_DIV: prod_last = (pc_r == 3'd5);
      default:           prod_last = (pc_r == 3'd1);
    endcase
  end

  // final rounding and clipping
  always_comb begin
    fin_re = '0;
    fin_im = '0;
    fin_st = cau_pkg::STAT_OK;
    case (it_r.kind)
      cau_pkg::KIND_MUL: begin
        fin_re = sat65(s_re_r >>> FRAC_BITS);
        fin_im = sat65(s_im_r >>> FRAC_BITS);
      end
      cau_pkg::KIND_DIV: begin
        if (!dz_r) begin
          fin_re = sat_sm(q_re_r, ov_re_r, s_re_r[64]);
          fin_im = sat_sm(q_im_r, ov_im_r, s_im_r[64]);
        end
      end
      default: begin
        fin_re = sat_sm(sres_r[32:0], |sres_r[63:33], 1'b0);
      end
    endcase
    if (it_r.kind == cau_pkg::KIND_DIV && dz_r) fin_st = cau_pkg::STAT_DIVZ;
    else if (fin_re.sat || fin_im.sat)          fin_st = cau_pkg::STAT_SAT;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cau_pkg::ST_IDLE: begin
        if (head.valid && head.item.kind != cau_pkg::KIND_SIMPLE) state_nxt = cau_pkg::ST_PROD;
      end
      cau_pkg::ST_PROD: if (prod_last) state_nxt = cau_pkg::ST_SUM;
      cau_pkg::ST_SUM: begin
        state_nxt = (it_r.kind == cau_pkg::KIND_MUL) ? cau_pkg::ST_FIN : cau_pkg::ST_PREP;
      end
      cau_pkg::ST_PREP: begin
        if (it_r.kind == cau_pkg::KIND_MAG) state_nxt = cau_pkg::ST_SQRT;
        else if (d_r == '0)                 state_nxt = cau_pkg::ST_FIN;
        else                                state_nxt = cau_pkg::ST_DIV;
      end
      cau_pkg::ST_DIV:  if (cnt_r == CW'(1)) state_nxt = cau_pkg::ST_FIN;
      cau_pkg::ST_SQRT: if (cnt_r == CW'(1)) state_nxt = cau_pkg::ST_FIN;
      cau_pkg::ST_FIN:  if (out_free) state_nxt = cau_pkg::ST_IDLE;
      default:          state_nxt = cau_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load_simple = 1'b0;
    load_fin    = 1'b0;
    pop         = 1'b0;
    unique case (state_r)
      cau_pkg::ST_IDLE: begin
        if (head.valid) begin
          if (head.item.kind == cau_pkg::KIND_SIMPLE) begin
            load_simple = out_free;
            pop         = out_free;
          end else begin
            pop = 1'b1;
          end
        end
      end
      cau_pkg::ST_FIN: load_fin = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_simple || load_fin) out_valid_r <= 1'b1;
      else if (out_chan.ready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [64:0] t_re, t_im;
    logic [63:0] sum_sq;
    t_re   = {r_re_r, n_re_r[NW-1]};
    t_im   = {r_im_r, n_im_r[NW-1]};
    sum_sq = sres_r + sbit_r;
    unique case (state_r)
      cau_pkg::ST_IDLE: begin
        it_r <= head.item;
        pc_r <= '0;
      end
      cau_pkg::ST_PROD: begin
        if (pc_r < 3'd6) p_r[pc_r] <= prod;
        pc_r <= pc_r + 1'b1;
      end
      cau_pkg::ST_SUM: begin
        case (it_r.kind)
          cau_pkg::KIND_MUL: begin
            s_re_r <= 65'(p_r[0]) - 65'(p_r[1]);
            s_im_r <= 65'(p_r[2]) + 65'(p_r[3]);
          end
          cau_pkg::KIND_DIV: begin
            d_r    <= p_r[0] + p_r[1];
            s_re_r <= 65'(p_r[2]) + 65'(p_r[3]);
            s_im_r <= 65'(p_r[4]) - 65'(p_r[5]);
          end
          default: d_r <= p_r[0] + p_r[1];
        endcase
      end
      cau_pkg::ST_PREP: begin
        dz_r    <= (d_r == '0);
        n_re_r  <= NW'(abs65(s_re_r)) << FRAC_BITS;
        n_im_r  <= NW'(abs65(s_im_r)) << FRAC_BITS;
        r_re_r  <= '0;
        r_im_r  <= '0;
        q_re_r  <= '0;
        q_im_r  <= '0;
        ov_re_r <= 1'b0;
        ov_im_r <= 1'b0;
        sx_r    <= d_r;
        sres_r  <= '0;
        sbit_r  <= 64'h4000_0000_0000_0000;
        cnt_r   <= (it_r.kind == cau_pkg::KIND_MAG) ? CW'(SQRT_STEPS) : CW'(NW);
      end
      cau_pkg::ST_DIV: begin
        n_re_r  <= n_re_r << 1;
        n_im_r  <= n_im_r << 1;
        ov_re_r <= ov_re_r | q_re_r[32];
        ov_im_r <= ov_im_r | q_im_r[32];
        if (t_re >= {1'b0, d_r}) begin
          r_re_r <= 64'(t_re - {1'b0, d_r});
          q_re_r <= {q_re_r[31:0], 1'b1};
        end else begin
          r_re_r <= t_re[63:0];
          q_re_r <= {q_re_r[31:0], 1'b0};
        end
        if (t_im >= {1'b0, d_r}) begin
          r_im_r <= 64'(t_im - {1'b0, d_r});
          q_im_r <= {q_im_r[31:0], 1'b1};
        end else begin
          r_im_r <= t_im[63:0];
          q_im_r <= {q_im_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      cau_pkg::ST_SQRT: begin
        if (sx_r >= sum_sq) begin
          sx_r   <= sx_r - sum_sq;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        cnt_r  <= cnt_r - 1'b1;
      end
      default: ;
    endcase

    if (load_simple) begin
      ore_r <= sim_re.val;
      oim_r <= sim_im.val;
      ost_r <= (sim_re.sat || sim_im.sat) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
    end else if (load_fin) begin
      ore_r <= fin_re.val;
      oim_r <= fin_im.val;
      ost_r <= fin_st;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.res_re = ore_r;
  assign out_chan.res_im = oim_r;
  assign out_chan.status = ost_r;

  `CAU_ASSERT_IMP(a_pop_idle, pop, state_r == cau_pkg::ST_IDLE)
  `CAU_ASSERT_NXT(a_div_end, state_r == cau_pkg::ST_DIV && cnt_r == CW'(1), state_r == cau_pkg::ST_FIN)
  `CAU_ASSERT_NXT(a_divz_out, load_fin && it_r.kind == cau_pkg::KIND_DIV && dz_r, out_chan.valid && out_chan.status == cau_pkg::STAT_DIVZ && out_chan.res_re == 32'sd0)

endmodule

>>> rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex ALU in signed fixed point: add, sub, mul, div, magnitude, negate,
// increment and decrement of the real part, with saturation status.
// ----------------------------------------------------------------------------
// Add, subtract, negate, increment and decrement complete one beat per cycle
// while the result register is free. Multiply, divide and magnitude share one
// 32x32 multiplier, one product per cycle; the divider retires one quotient
// bit per cycle for both parts and the square root one result bit per cycle.
// A QUEUE_DEPTH entry queue sits before the execution unit and the result is
// registered, so operands keep being taken while a long operation runs or a
// result waits.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS   = cau_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = cau_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cau_in_if.sink     in_chan,
  cau_out_if.source  out_chan
);

  cau_pkg::qport_t push, head;
  logic            q_full, pop;

  cau_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push)
  );

  cau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

>>> bench/cau_tb_if.sv
// ----------------------------------------------------------------------------
// cau_tb_if
// Channel interfaces are supplied with the RTL; this package holds beat types.
// ----------------------------------------------------------------------------
package cau_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } operand_beat_t;

  typedef struct {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;
  } result_beat_t;
endpackage

>>> bench/tb_complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives operand beats through the complex ALU and checks every result beat
// against typed-in or bit-exact predicted values; directed rows, then random.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;
  import cau_tb_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1700;
  localparam int WDOG_MAX  = 20000;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] QONE = 32'sh00010000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  cau_in_if  in_chan();
  cau_out_if out_chan();

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  result_beat_t expected_q[$];
  int  n_fail = 0, n_checked = 0, n_sent = 0;
  int  idle_cycles = 0;
  bit  sending_done = 1'b0;
  int  op_count[8];

  // ---------------- predictor ----------------
  function automatic logic signed [31:0] clip(logic signed [127:0] v, inout logic [1:0] st);
    if (v > 128'sd2147483647) begin st = STAT_SAT; return QMAX; end
    if (v < -128'sd2147483648) begin st = STAT_SAT; return QMIN; end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] floor_shift(logic signed [127:0] v);
    return v >>> FB;
  endfunction

  function automatic logic signed [127:0] trunc_div(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d; // SV signed division truncates toward zero
    return q;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic result_beat_t predict_result(operand_beat_t o);
    result_beat_t r;
    logic signed [127:0] ar, ai, br, bi, d;
    logic [1:0] st;
    ar = 128'(o.a_re); ai = 128'(o.a_im); br = 128'(o.b_re); bi = 128'(o.b_im);
    st = STAT_OK;
    r.res_re = '0; r.res_im = '0;
    case (action_t'(o.action))
      ACT_ADD: begin r.res_re = clip(ar + br, st); r.res_im = clip(ai + bi, st); end
      ACT_SUB: begin r.res_re = clip(ar - br, st); r.res_im = clip(ai - bi, st); end
      ACT_MUL: begin
        r.res_re = clip(floor_shift(ar * br - ai * bi), st);
        r.res_im = clip(floor_shift(ai * br + ar * bi), st);
      end
      ACT_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) st = STAT_DIVZ;
        else begin
          r.res_re = clip(trunc_div((ar * br + ai * bi) <<< FB, d), st);
          r.res_im = clip(trunc_div((ai * br - ar * bi) <<< FB, d), st);
        end
      end
      ACT_MAG: r.res_re = clip(128'(root_floor(64'(ar * ar + ai * ai))), st);
      ACT_NEG: begin r.res_re = clip(-ar, st); r.res_im = clip(-ai, st); end
      ACT_INC: begin r.res_re = clip(ar + (128'sd1 <<< FB), st); r.res_im = o.a_im; end
      default: begin r.res_re = clip(ar - (128'sd1 <<< FB), st); r.res_im = o.a_im; end
    endcase
    r.status = st;
    return r;
  endfunction

  // ---------------- directed table ----------------
  // has_exp marks rows whose result is typed in by hand
  typedef struct {
    operand_beat_t op;
    bit            has_exp;
    result_beat_t  exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk(action_t a, logic signed [31:0] ar, ai, br, bi,
                                  bit he = 1'b0, logic signed [31:0] er = 0,
                                  logic signed [31:0] ei = 0, logic [1:0] es = STAT_OK);
    dir_row_t d;
    d.op = '{a, ar, ai, br, bi};
    d.has_exp = he;
    d.exp = '{er, ei, es};
    return d;
  endfunction

  initial begin
    dir_rows.push_back(mk(ACT_ADD, QMAX, QMIN, QONE, -QONE, 1, QMAX, QMIN, STAT_SAT));
    dir_rows.push_back(mk(ACT_ADD, 3, -4, 5, 6, 1, 8, 2, STAT_OK));
    dir_rows.push_back(mk(ACT_SUB, QMIN, QMAX, 1, -1, 1, QMIN, QMAX, STAT_SAT));
    dir_rows.push_back(mk(ACT_SUB, QMAX, QMIN, QMAX, QMIN, 1, 0, 0, STAT_OK));
    dir_rows.push_back(mk(ACT_MUL, QONE, QONE, QONE, -QONE));
    dir_rows.push_back(mk(ACT_MUL, QMAX, QMAX, QMAX, QMAX));
    dir_rows.push_back(mk(ACT_MUL, QMIN, QMIN, QMIN, QMIN));
    dir_rows.push_back(mk(ACT_MUL, -1, 1, 1, 1));
    dir_rows.push_back(mk(ACT_DIV, QONE, 0, 0, 0, 1, 0, 0, STAT_DIVZ));
    dir_rows.push_back(mk(ACT_DIV, QMAX, QMIN, 0, 0, 1, 0, 0, STAT_DIVZ));
    dir_rows.push_back(mk(ACT_DIV, QMAX, QMIN, 1, 0));
    dir_rows.push_back(mk(ACT_DIV, QONE, QONE, QONE, QONE));
    dir_rows.push_back(mk(ACT_DIV, -7, 3, QMIN, QMAX));
    dir_rows.push_back(mk(ACT_DIV, QMIN, QMIN, QMIN, QMIN));
    dir_rows.push_back(mk(ACT_MAG, 3 * QONE, 4 * QONE, 0, 0));
    dir_rows.push_back(mk(ACT_MAG, QMIN, QMIN, 0, 0, 1, QMAX, 0, STAT_SAT));
    dir_rows.push_back(mk(ACT_MAG, 0, 0, QMAX, QMAX, 1, 0, 0, STAT_OK));
    dir_rows.push_back(mk(ACT_NEG, QMIN, QMAX, 0, 0, 1, QMAX, QMIN + 1, STAT_SAT));
    dir_rows.push_back(mk(ACT_NEG, 5, -5, 1, 1, 1, -5, 5, STAT_OK));
    dir_rows.push_back(mk(ACT_INC, QMAX, QMIN, 0, 0, 1, QMAX, QMIN, STAT_SAT));
    dir_rows.push_back(mk(ACT_INC, -QONE, 7, 0, 0, 1, 0, 7, STAT_OK));
    dir_rows.push_back(mk(ACT_DEC, QMIN, QMAX, 0, 0, 1, QMIN, QMAX, STAT_SAT));
    dir_rows.push_back(mk(ACT_DEC, QONE, -9, 0, 0, 1, 0, -9, STAT_OK));
  end

  // ---------------- random operands ----------------
  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: return QMAX;
      1: return QMIN;
      2: return 32'($urandom_range(0, 3)) - 1;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic operand_beat_t rand_beat();
    operand_beat_t o;
    o.action = 3'($urandom_range(0, 7));
    o.a_re = rand_part(); o.a_im = rand_part();
    o.b_re = rand_part(); o.b_im = rand_part();
    if (o.action == ACT_DIV && $urandom_range(0, 15) == 0) begin
      o.b_re = 0; o.b_im = 0;
    end
    return o;
  endfunction

  // ---------------- sender ----------------
  task automatic send_beat(operand_beat_t o);
    in_chan.valid  <= 1'b1;
    in_chan.action <= o.action;
    in_chan.a_re <= o.a_re; in_chan.a_im <= o.a_im;
    in_chan.b_re <= o.b_re; in_chan.b_im <= o.b_im;
    do @(posedge clk); while (!in_chan.ready);
    op_count[o.action]++;
    n_sent++;
    @(negedge clk);
  endtask

  task automatic gap();
    in_chan.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  initial begin
    operand_beat_t o;
    int burst;
    in_chan.valid = 1'b0;
    in_chan.action = '0;
    in_chan.a_re = '0; in_chan.a_im = '0; in_chan.b_re = '0; in_chan.b_im = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) expected_q.push_back(dir_rows[i].exp);
      else expected_q.push_back(predict_result(dir_rows[i].op));
      send_beat(dir_rows[i].op);
      if ($urandom_range(0, 3) == 0) gap();
    end

    // drain fully once, with nothing in flight
    in_chan.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);

    burst = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (burst == 0) begin
        if (k > 200) gap();
        burst = $urandom_range(1, 40);
      end
      burst--;
      o = rand_beat();
      expected_q.push_back(predict_result(o));
      send_beat(o);
    end
    in_chan.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // ---------------- receiver ----------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      // stall pattern: long open stretches, then choppy phases
      if ((n_checked / 150) % 3 == 0) out_chan.ready <= 1'b1;
      else out_chan.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    result_beat_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: re=%h im=%h st=%0d",
               out_chan.res_re, out_chan.res_im, out_chan.status);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (out_chan.res_re !== e.res_re) begin
          $error("res_re: expected %h actual %h", e.res_re, out_chan.res_re); n_fail++;
        end
        if (out_chan.res_im !== e.res_im) begin
          $error("res_im: expected %h actual %h", e.res_im, out_chan.res_im); n_fail++;
        end
        if (out_chan.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_chan.status); n_fail++;
        end
        n_checked++;
      end
    end
  end

  // ---------------- watchdog and end of run ----------------
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (!(idle_cycles >= WDOG_MAX || (sending_done && expected_q.size() == 0)))
      @(posedge clk);
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog: %0d results outstanding", expected_q.size());
      $display("tb_complex_arithmetic_unit failed");
      $finish;
    end else begin
      repeat (200) @(posedge clk);
      $display("covered %0d operand beats, %0d results checked", n_sent, n_checked);
      $display("per action add..dec: %0d %0d %0d %0d %0d %0d %0d %0d", op_count[0],
               op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
               op_count[6], op_count[7]);
      if (n_fail == 0 && expected_q.size() == 0) $display("tb_complex_arithmetic_unit passed");
      else $display("tb_complex_arithmetic_unit failed");
      $finish;
    end
  end
endmodule
